// ===== src/mrrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants of the Modbus RTU response checker
// Holds the result record passed between the stages, status codes and the
// byte-wise reflected CRC-16 update.
// ----------------------------------------------------------------------------
package mrrc_pkg;

	// CRC-16 (Modbus) constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// expected function code after reset
	localparam logic [7:0] EXP_FUNC_RST = 8'd3;

	// frame status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CRC   = 2'd1;
	localparam logic [1:0] ST_FUNC  = 2'd2;
	localparam logic [1:0] ST_SHORT = 2'd3;

	// result queue depth and pointer width
	localparam int QDEPTH = 2;
	localparam int QPW    = 1;

	// one result item
	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_done;
		logic [1:0] frame_status;
		logic [7:0] byte_count;
	} mrrc_result_t;

	// fold one byte into the reflected CRC, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== src/mrrc_front.sv =====
// ----------------------------------------------------------------------------
// mrrc_front: frame tracking, CRC and classification
// Accepts received bytes, keeps the frame position, delay line and CRC, and
// forms a result record for each byte that yields payload or ends a frame.
// ----------------------------------------------------------------------------
module mrrc_front import mrrc_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   rx_byte,
	input  logic         end_of_frame,
	input  logic         q_full,
	output logic         q_push,
	output mrrc_result_t q_data
);

	localparam int PW   = $clog2(MAX_FRAME + 1);
	localparam int CMPW = PW + 8;

	logic [7:0]    exp_func_q;
	logic          started_q;
	logic [PW-1:0] frame_pos_q;
	logic [15:0]   crc_q;
	logic [7:0]    tail0_q;
	logic [7:0]    tail1_q;
	logic [7:0]    count_q;
	logic [7:0]    func_q;

	logic          accept;
	logic          keep;
	logic          past2;
	logic          in_range;
	logic [PW-1:0] pos_rel;
	logic [15:0]   crc_next;
	logic [7:0]    count_next;
	logic          pv;
	logic [1:0]    status;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the incoming byte
	always_comb begin
		keep      = started_q || (rx_byte != 8'd0);
		past2     = (frame_pos_q >= PW'(2));
		crc_next  = past2 ? crc16_byte(crc_q, tail1_q) : crc_q;
		pos_rel   = frame_pos_q - PW'(5);
		in_range  = (frame_pos_q < PW'(MAX_FRAME)) && (frame_pos_q >= PW'(5)) &&
			(CMPW'(pos_rel) < CMPW'(count_q));
		pv        = keep && in_range;
		count_next = (keep && frame_pos_q == PW'(2)) ? rx_byte : count_q;
		if (!keep || frame_pos_q < PW'(3)) begin
			status = ST_SHORT;
		end else if (tail0_q != crc_next[7:0] || rx_byte != crc_next[15:8]) begin
			status = ST_CRC;
		end else if (func_q != exp_func_q) begin
			status = ST_FUNC;
		end else begin
			status = ST_OK;
		end
	end

	// build the result record
	always_comb begin
		q_push                = accept && (pv || end_of_frame);
		q_data.payload_valid  = pv;
		q_data.payload_byte   = pv ? tail1_q : 8'd0;
		q_data.frame_done     = end_of_frame;
		q_data.frame_status   = end_of_frame ? status : ST_OK;
		q_data.byte_count     = count_next;
	end

	// hold the expected function code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_func_q <= EXP_FUNC_RST;
		end else if (cfg_we) begin
			exp_func_q <= cfg_wdata;
		end
	end

	// advance frame state; clear at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			frame_pos_q <= '0;
			crc_q       <= CRC_INIT;
			tail0_q     <= 8'd0;
			tail1_q     <= 8'd0;
			count_q     <= 8'd0;
			func_q      <= 8'd0;
		end else if (accept) begin
			if (end_of_frame) begin
				started_q   <= 1'b0;
				frame_pos_q <= '0;
				crc_q       <= CRC_INIT;
				tail0_q     <= 8'd0;
				tail1_q     <= 8'd0;
				count_q     <= 8'd0;
				func_q      <= 8'd0;
			end else begin
				started_q <= 1'b1;
				if (keep) begin
					crc_q   <= crc_next;
					tail1_q <= tail0_q;
					tail0_q <= rx_byte;
					count_q <= count_next;
					if (frame_pos_q == PW'(1)) begin
						func_q <= rx_byte;
					end
					if (frame_pos_q < PW'(MAX_FRAME)) begin
						frame_pos_q <= frame_pos_q + PW'(1);
					end
				end
			end
		end
	end

	// every frame end yields a result
	a_eof_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_frame) |-> q_push)
		else $error("frame end without result");

	// status is only reported with frame end
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_data.frame_status != ST_OK) |-> q_data.frame_done)
		else $error("status without frame end");

	// position never passes its ceiling
	a_pos_max: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos_q <= PW'(MAX_FRAME))
		else $error("frame position overrun");

endmodule

// ===== src/mrrc_queue.sv =====
// ----------------------------------------------------------------------------
// mrrc_queue: result queue between front and back
// Two-entry register queue so that either side may stall on its own.
// ----------------------------------------------------------------------------
module mrrc_queue import mrrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mrrc_result_t wr_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output mrrc_result_t rd_data
);

	mrrc_result_t   mem_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (count_q == (QPW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// store the written entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

	// fill level stays within depth
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPW+1)'(QDEPTH))
		else $error("queue level out of range");

	// a push never meets a full queue
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	// level tracks a lone push
	a_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + (QPW+1)'(1))
		else $error("queue level not advanced");

endmodule

// ===== src/mrrc_back.sv =====
// ----------------------------------------------------------------------------
// mrrc_back: result output stage
// Pulls results from the queue into an output register and presents them on
// the master stream.
// ----------------------------------------------------------------------------
module mrrc_back import mrrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  mrrc_result_t q_data,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_ready,
	output mrrc_result_t out_data
);

	logic         valid_q;
	mrrc_result_t res_q;

	assign q_pop     = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = res_q;

	// hold the valid flag until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	// load the next result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_data;
		end
	end

	// held beat stays put while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && res_q == $past(res_q)))
		else $error("output beat changed under stall");

	// every shown beat is payload or frame end
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.payload_valid || res_q.frame_done))
		else $error("empty result shown");

	// a waiting result is loaded when the register frees up
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(q_not_empty && (!valid_q || out_ready)) |=> valid_q)
		else $error("queued result not loaded");

endmodule

// ===== src/modbus_rtu_response_checker_top.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_top: Modbus RTU response CRC and header check
// Checks one received response frame per run of bytes and forwards payload.
//
//   channel  dir  beat contents
//   s_*      in   tdata[7:0] rx_byte; tlast end_of_frame
//   m_*      out  tdata[7:0] payload_byte, [9:8] frame_status,
//                 [17:10] byte_count; tuser payload_valid; tlast frame_done
//   cfg_*    in   cfg_wdata expected_function, written when cfg_we is high
//
// One byte is taken per cycle while the queue is not full; the byte CRC is
// combinational XOR logic in the front; results reach m_tdata via the queue, then the output register.
// s_tready drops only while the two-entry result queue is full.
// arst_n clears frame state and sets the expected function code to 3.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_top import mrrc_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
	                               // [17:10] byte_count, [23:18] zero
	output logic        m_tuser,   // [0] payload_valid
	output logic        m_tlast
);

	logic         q_full;
	logic         q_push;
	mrrc_result_t q_wr;
	logic         q_pop;
	logic         q_not_empty;
	mrrc_result_t q_rd;
	mrrc_result_t res;

	mrrc_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.rx_byte      (s_tdata),
		.end_of_frame (s_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wr)
	);

	mrrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_rd)
	);

	mrrc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_rd),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (res)
	);

	// pack the result beat
	assign m_tdata = {6'd0, res.byte_count, res.frame_status, res.payload_byte};
	assign m_tuser = res.payload_valid;
	assign m_tlast = res.frame_done;

endmodule
